>>> hdl/kars_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kars_pkg
// Shared types, constants and the key mask table for the keypad auto-repeat
// scanner.
// ----------------------------------------------------------------------------
package kars_pkg;

  localparam int KEY_BITS    = 12;
  localparam int STAMP_BITS  = 32;
  localparam int CODE_BITS   = 4;
  localparam int DELAY_BITS  = 16;
  localparam int NUM_ROWS    = 13;
  localparam int TIME_BITS_DEF = 32;

  // Stream widths, padded to whole bytes
  localparam int IN_TDATA_BITS  = 48;
  localparam int OUT_TDATA_BITS = 8;

  // Config port
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [DELAY_BITS-1:0] INITIAL_DELAY_RST = 16'd500;
  localparam logic [DELAY_BITS-1:0] REPEAT_DELAY_RST  = 16'd175;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_INITIAL_DELAY = 1'b0,
    REG_REPEAT_DELAY  = 1'b1
  } reg_idx_t;

  // Key rows in table order; a row is pressed when all masked bits are low
  localparam logic [KEY_BITS-1:0] ROW_MASK [NUM_ROWS] = '{
    12'h003, 12'h002, 12'h001, 12'h080, 12'h040, 12'h010, 12'h020,
    12'h100, 12'h004, 12'h008, 12'h400, 12'h200, 12'h800
  };

  typedef struct packed {
    logic [DELAY_BITS-1:0] initial_delay_ms;
    logic [DELAY_BITS-1:0] repeat_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   raw_keys;
    logic [STAMP_BITS-1:0] now_ms;
    logic                  clear_repeat;
  } scan_t;

  // Pressed flags for all rows of one key word
  function automatic logic [NUM_ROWS-1:0] rows_pressed(input logic [KEY_BITS-1:0] keys);
    logic [NUM_ROWS-1:0] res;
    for (int r = 0; r < NUM_ROWS; r++) begin
      res[r] = ((keys & ROW_MASK[r]) == '0);
    end
    return res;
  endfunction

endpackage

>>> hdl/key_autorepeat_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_autorepeat_scanner_top
// Keypad scanner with click detection and auto-repeat, stream in and out,
// APB delay registers.
// ----------------------------------------------------------------------------
// Every scan transfer gives exactly one result transfer carrying key_code
// (0 for no event, else the table row 1..13 clicked or repeated). One scan
// is taken per clock cycle while the output is not stalled; a taken scan
// is held in the input register, and its result is presented from the
// result register. The single evaluation stage between the input register
// and the result register holds the priority match over the 13 rows and
// one time compare. A stalled output holds the result and stops the input
// register, so no transfer is lost. The user must write the delays through
// APB only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module key_autorepeat_scanner_top
  import kars_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Scan stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // [11:0] raw_keys, [43:12] now_ms, pad
  input  logic                      in_tuser,   // [0] clear_repeat
  // Result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,  // [3:0] key_code, pad
  // Config port
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [APB_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [APB_DATA_BITS-1:0]  cfg_pwdata,
  output logic [APB_DATA_BITS-1:0]  cfg_prdata,
  output logic                      cfg_pready
);

  cfg_t                 cfg;
  scan_t                in_scan, scan;
  logic                 scan_valid, advance;
  logic [CODE_BITS-1:0] key_code;

  assign in_scan.raw_keys     = in_tdata[KEY_BITS-1:0];
  assign in_scan.now_ms       = in_tdata[KEY_BITS +: STAMP_BITS];
  assign in_scan.clear_repeat = in_tuser;

  kars_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  kars_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_scan    (in_scan),
    .advance    (advance),
    .scan_valid (scan_valid),
    .scan       (scan)
  );

  kars_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .scan_valid (scan_valid),
    .scan       (scan),
    .advance    (advance),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .key_code   (key_code)
  );

  assign out_tdata = OUT_TDATA_BITS'(key_code);

endmodule

>>> hdl/kars_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kars_regs
// APB register file holding the initial and repeat delays.
// ----------------------------------------------------------------------------
module kars_regs
  import kars_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_INITIAL_DELAY: cfg_nxt.initial_delay_ms = pwdata[DELAY_BITS-1:0];
        REG_REPEAT_DELAY:  cfg_nxt.repeat_delay_ms  = pwdata[DELAY_BITS-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_delay_ms <= INITIAL_DELAY_RST;
      cfg_r.repeat_delay_ms  <= REPEAT_DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_INITIAL_DELAY: prdata = APB_DATA_BITS'(cfg_r.initial_delay_ms);
      REG_REPEAT_DELAY:  prdata = APB_DATA_BITS'(cfg_r.repeat_delay_ms);
      default:           prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/kars_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kars_in_reg
// Input register: captures one scan per transfer and holds it until the
// evaluation stage takes it.
// ----------------------------------------------------------------------------
module kars_in_reg
  import kars_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  scan_t in_scan,
  input  logic  advance,
  output logic  scan_valid,
  output scan_t scan
);

  logic  valid_r, valid_nxt;
  scan_t scan_r;
  logic  take;

  // Free when empty or when the held scan moves on this cycle
  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      scan_r <= in_scan;
    end
  end

  assign scan_valid = valid_r;
  assign scan       = scan_r;

endmodule

>>> hdl/kars_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kars_core
// Click detection and auto-repeat timing for one scan, with the scan state
// and the result register.
// ----------------------------------------------------------------------------
module kars_core
  import kars_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 scan_valid,
  input  scan_t                scan,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CODE_BITS-1:0] key_code
);

  localparam int PAD_ROWS = (1 << CODE_BITS) - NUM_ROWS;

  // Scan state
  logic [KEY_BITS-1:0]  prev_keys_r, prev_keys_nxt;
  logic [CODE_BITS-1:0] held_r, held_nxt;
  logic [TIME_BITS-1:0] last_time_r, last_time_nxt;
  logic                 has_rep_r, has_rep_nxt;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  logic [CODE_BITS-1:0] code_r, code_nxt;

  logic                          step;
  logic [NUM_ROWS-1:0]           pressed_now, pressed_prev, click_vec;
  logic [(1 << CODE_BITS)-1:0]   pressed_pad;
  logic [CODE_BITS-1:0]          click_row, held_eff, held_idx, code;
  logic                          clicked, held_pressed, fire;
  logic [TIME_BITS-1:0]          now_t, diff, delay_t;

  assign advance = !out_valid_r || out_ready;
  assign step    = scan_valid && advance;

  // Row press detection and first new click in table order
  assign pressed_now  = rows_pressed(scan.raw_keys);
  assign pressed_prev = rows_pressed(prev_keys_r);
  assign click_vec    = pressed_now & ~pressed_prev;
  assign clicked      = |click_vec;

  always_comb begin
    click_row = '0;
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (click_vec[r]) begin
        click_row = CODE_BITS'(r + 1);
      end
    end
  end

  // Held key, after the clear flag; codes past the table read as released
  assign held_eff     = scan.clear_repeat ? '0 : held_r;
  assign held_idx     = held_eff - CODE_BITS'(1);
  assign pressed_pad  = {{PAD_ROWS{1'b0}}, pressed_now};
  assign held_pressed = (held_eff != '0) && pressed_pad[held_idx];

  // Modular elapsed time; a negative difference never fires
  assign now_t   = TIME_BITS'(scan.now_ms);
  assign diff    = now_t - last_time_r;
  assign delay_t = TIME_BITS'(has_rep_r ? cfg.repeat_delay_ms : cfg.initial_delay_ms);
  assign fire    = !diff[TIME_BITS-1] && (diff > delay_t);

  // Next state and result
  always_comb begin
    prev_keys_nxt = prev_keys_r;
    held_nxt      = held_r;
    last_time_nxt = last_time_r;
    has_rep_nxt   = has_rep_r;
    code          = '0;
    if (clicked) begin
      held_nxt      = click_row;
      has_rep_nxt   = 1'b0;
      last_time_nxt = now_t;
      code          = click_row;
    end else if (held_pressed) begin
      held_nxt = held_eff;
      if (fire) begin
        has_rep_nxt   = 1'b1;
        last_time_nxt = now_t;
        code          = held_eff;
      end
    end else begin
      held_nxt = '0;
    end
    if (step) begin
      prev_keys_nxt = scan.raw_keys;
    end else begin
      held_nxt      = held_r;
      last_time_nxt = last_time_r;
      has_rep_nxt   = has_rep_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    code_nxt      = code_r;
    if (advance) begin
      out_valid_nxt = scan_valid;
      code_nxt      = code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_keys_r <= '1;
      held_r      <= '0;
      last_time_r <= '0;
      has_rep_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prev_keys_r <= prev_keys_nxt;
      held_r      <= held_nxt;
      last_time_r <= last_time_nxt;
      has_rep_r   <= has_rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign out_valid = out_valid_r;
  assign key_code  = code_r;

endmodule

>>> hdl/kars_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kars_chk
// Port-level checks for the keypad auto-repeat scanner, bound to the top.
// ----------------------------------------------------------------------------
module kars_chk
  import kars_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [OUT_TDATA_BITS-1:0] out_tdata,
  input logic                      cfg_pready
);

  // Result code stays within the key table
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[CODE_BITS-1:0] <= 4'(NUM_ROWS)))
    else $error("key code outside table");

  // A scan taken and then met by a ready output yields a valid result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("scan result missing");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // Config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("cfg_pready low");

endmodule

bind key_autorepeat_scanner_top kars_chk u_kars_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

>>> tb/key_autorepeat_scanner_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_autorepeat_scanner_top_test
// Self-checking bench for the keypad auto-repeat scanner.
// ----------------------------------------------------------------------------
// Scans are sent on the input stream. A model of the click and auto-repeat
// logic, kept inside this bench, predicts the key code of each accepted scan
// and queues it. Every result transfer is checked against the oldest queued
// code. The directed tests cover each key row, the exact delay boundaries,
// timestamp wrap, negative time differences, a click while another key is
// held and the clear flag. Random traffic then mostly holds keys across
// several scans under a range of delay settings. Both stream sides idle at
// random, and in one test the output stalls long enough to back up the input.
// ----------------------------------------------------------------------------
module key_autorepeat_scanner_top_test;
  import kars_pkg::*;

  localparam int PAD_BITS       = IN_TDATA_BITS - KEY_BITS - STAMP_BITS;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 4;
  localparam int SHOWN_ERRORS   = 10;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata;   // [11:0] raw_keys, [43:12] now_ms, pad
  logic                      in_tuser;   // [0] clear_repeat
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_TDATA_BITS-1:0] out_tdata;  // [3:0] key_code, pad
  logic                      cfg_psel;
  logic                      cfg_penable;
  logic                      cfg_pwrite;
  logic [APB_ADDR_BITS-1:0]  cfg_paddr;
  logic [APB_DATA_BITS-1:0]  cfg_pwdata;
  logic [APB_DATA_BITS-1:0]  cfg_prdata;
  logic                      cfg_pready;

  key_autorepeat_scanner_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Scanner model state
  logic [DELAY_BITS-1:0] init_delay;
  logic [DELAY_BITS-1:0] rep_delay;
  logic [KEY_BITS-1:0]   last_keys;
  logic [CODE_BITS-1:0]  held_row;
  logic [STAMP_BITS-1:0] last_event_stamp;
  logic                  held_repeated;

  logic [CODE_BITS-1:0]  exp_codes[$];
  int                    scan_count;
  int                    mismatch_count;
  logic [STAMP_BITS-1:0] stamp_now;
  bit                    idle_en;
  bit                    holdoff_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Key code for one scan; updates the model state
  function automatic logic [CODE_BITS-1:0] predict_key_code(
    input logic [KEY_BITS-1:0]   keys,
    input logic [STAMP_BITS-1:0] stamp,
    input logic                  clr
  );
    logic [NUM_ROWS-1:0]   was_down;
    logic [NUM_ROWS-1:0]   is_down;
    logic [STAMP_BITS-1:0] elapsed;
    logic [DELAY_BITS-1:0] wait_ms;
    logic [CODE_BITS-1:0]  code;
    int                    click_row;
    for (int r = 0; r < NUM_ROWS; r++) begin
      was_down[r] = (last_keys & ROW_MASK[r]) == '0;
      is_down[r]  = (keys & ROW_MASK[r]) == '0;
    end
    code      = '0;
    click_row = -1;
    if (clr) held_row = '0;
    last_keys = keys;
    // first newly pressed row in table order wins
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (!was_down[r] && is_down[r]) click_row = r;
    end
    if (click_row >= 0) begin
      held_row         = CODE_BITS'(click_row + 1);
      held_repeated    = 1'b0;
      last_event_stamp = stamp;
      code             = held_row;
    end else if (held_row >= 1 && held_row <= NUM_ROWS && is_down[held_row - 1]) begin
      elapsed = stamp - last_event_stamp;
      wait_ms = held_repeated ? rep_delay : init_delay;
      // negative differences never fire; compare is strict
      if (!elapsed[STAMP_BITS-1] && elapsed > STAMP_BITS'(wait_ms)) begin
        held_repeated    = 1'b1;
        last_event_stamp = stamp;
        code             = held_row;
      end
    end else begin
      held_row = '0;
    end
    return code;
  endfunction

  // Next timestamp: small steps, exact delay edges and rare far jumps
  function automatic logic [STAMP_BITS-1:0] next_stamp(input logic [STAMP_BITS-1:0] cur);
    int unsigned gap;
    gap = held_repeated ? rep_delay : init_delay;
    case ($urandom_range(9))
      0, 1:    return cur + $urandom_range(0, 3);
      2, 3:    return last_event_stamp + gap + $urandom_range(0, 1);
      4, 5, 6: return cur + $urandom_range(0, gap / 2 + 4);
      7, 8:    return cur + $urandom_range(0, gap + 16);
      default: return $urandom();
    endcase
  endfunction

  // One scan transfer, with random idle cycles ahead of it
  task automatic send_scan(
    input logic [KEY_BITS-1:0]   keys,
    input logic [STAMP_BITS-1:0] stamp,
    input logic                  clr
  );
    while (idle_en && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_BITS{1'b0}}, stamp, keys};
    in_tuser  <= clr;
    do @(posedge clk); while (!in_tready);
    exp_codes.push_back(predict_key_code(keys, stamp, clr));
    scan_count++;
  endtask

  // Stop sending and let all pending results come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (exp_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DELAY_BITS-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'($urandom), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_INITIAL_DELAY) init_delay = val;
    else rep_delay = val;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_delays(input logic [DELAY_BITS-1:0] first, input logic [DELAY_BITS-1:0] next);
    drain_results();
    write_reg(REG_INITIAL_DELAY, first);
    write_reg(REG_REPEAT_DELAY, next);
  endtask

  // Mostly held keys over several scans, some noise and broken holds
  task automatic run_random_scans(input int count);
    int                  goal;
    int                  hold_len;
    logic [KEY_BITS-1:0] keys;
    goal = scan_count + count;
    while (scan_count < goal) begin
      if ($urandom_range(99) < 85) begin
        keys = ~ROW_MASK[$urandom_range(NUM_ROWS - 1)];
        if ($urandom_range(3) == 0) keys[$urandom_range(KEY_BITS - 1)] = 1'b0;
        hold_len = $urandom_range(1, 12);
        repeat (hold_len) begin
          stamp_now = next_stamp(stamp_now);
          send_scan(keys, stamp_now, $urandom_range(29) == 0);
        end
        stamp_now = next_stamp(stamp_now);
        send_scan(($urandom_range(3) == 0) ? KEY_BITS'($urandom) : {KEY_BITS{1'b1}},
                  stamp_now, 1'b0);
      end else begin
        stamp_now = next_stamp(stamp_now);
        send_scan(KEY_BITS'($urandom), stamp_now, $urandom_range(3) == 0);
      end
    end
  endtask

  // Each row clicked once, all keys down, timestamp extremes
  task automatic test_row_clicks();
    send_scan({KEY_BITS{1'b1}}, 32'h0000_0000, 1'b0);
    send_scan(~ROW_MASK[2], 32'd1, 1'b0);
    send_scan(~ROW_MASK[1], 32'd2, 1'b0);
    send_scan(~ROW_MASK[0], 32'd3, 1'b0);
    for (int r = 3; r < NUM_ROWS; r++) send_scan(~ROW_MASK[r], 32'(r + 1), 1'b0);
    send_scan({KEY_BITS{1'b0}}, 32'hFFFF_FFFF, 1'b1);
    send_scan({KEY_BITS{1'b1}}, 32'hFFFF_FFFF, 1'b0);
  endtask

  // Delay edges, click while held, clear flag, wrap and negative difference
  task automatic test_repeat_timing();
    set_delays(16'd10, 16'd5);
    send_scan(~ROW_MASK[3], 32'd1000, 1'b0);
    send_scan(~ROW_MASK[3], 32'd1010, 1'b0);   // equal to delay: quiet
    send_scan(~ROW_MASK[3], 32'd1011, 1'b0);   // first repeat
    send_scan(~ROW_MASK[3], 32'd1016, 1'b0);
    send_scan(~ROW_MASK[3], 32'd1017, 1'b0);   // next repeat
    send_scan(~(ROW_MASK[3] | ROW_MASK[4]), 32'd1018, 1'b0);  // new click
    send_scan(~(ROW_MASK[3] | ROW_MASK[4]), 32'd1030, 1'b0);
    send_scan(~(ROW_MASK[3] | ROW_MASK[4]), 32'd1100, 1'b1);  // clear while held
    send_scan(~(ROW_MASK[3] | ROW_MASK[4]), 32'd1200, 1'b0);
    send_scan({KEY_BITS{1'b1}}, 32'd1201, 1'b0);
    send_scan(~ROW_MASK[5], 32'hFFFF_FFF8, 1'b0);
    send_scan(~ROW_MASK[5], 32'h0000_0008, 1'b0);   // across the wrap
    send_scan(~ROW_MASK[5], 32'h8000_0008, 1'b0);   // half range: negative
    send_scan(~ROW_MASK[5], 32'h0000_0030, 1'b0);
    send_scan({KEY_BITS{1'b1}}, 32'h0000_0031, 1'b0);
  endtask

  task automatic test_extreme_delays();
    set_delays(16'd0, 16'd0);
    run_random_scans(360);
    set_delays(16'hFFFF, 16'hFFFF);
    run_random_scans(360);
  endtask

  // Long run with neither side idling
  task automatic test_steady_stream();
    set_delays(DELAY_BITS'($urandom_range(0, 40)), DELAY_BITS'($urandom_range(0, 40)));
    idle_en = 1'b0;
    run_random_scans(360);
    idle_en = 1'b1;
  endtask

  // Output stalls for a long stretch while scans keep coming
  task automatic test_output_holdoff();
    set_delays(16'd20, 16'd7);
    holdoff_req = 1'b1;
    run_random_scans(120);
  endtask

  task automatic test_random_delays();
    set_delays(16'($urandom), 16'($urandom));
    run_random_scans(360);
    set_delays(DELAY_BITS'($urandom_range(1, 300)), DELAY_BITS'($urandom_range(1, 300)));
    run_random_scans(360);
  endtask

  // Result receiver: random stalls, or a long hold-off on request
  initial begin : result_sink
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (holdoff_req) begin
        repeat (HOLDOFF_CYCLES) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
        holdoff_req = 1'b0;
      end else begin
        out_tready <= !(idle_en && $urandom_range(99) < 18);
        @(posedge clk);
      end
    end
  end

  // Compare each result transfer with the oldest predicted code
  always @(posedge clk) begin : result_check
    logic [CODE_BITS-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_codes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
          $display("%0t: unexpected result, key_code %0d", $realtime, out_tdata[CODE_BITS-1:0]);
      end else begin
        want = exp_codes.pop_front();
        if (out_tdata[CODE_BITS-1:0] !== want) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_ERRORS)
            $display("%0t: key_code expected %0d, got %0d", $realtime, want,
                     out_tdata[CODE_BITS-1:0]);
        end
      end
    end
  end

  // Ends the run when no transfer happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main_seq
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    init_delay       = INITIAL_DELAY_RST;
    rep_delay        = REPEAT_DELAY_RST;
    last_keys        = {KEY_BITS{1'b1}};
    held_row         = '0;
    last_event_stamp = '0;
    held_repeated    = 1'b0;
    scan_count       = 0;
    mismatch_count   = 0;
    stamp_now        = '0;
    idle_en          = 1'b1;
    holdoff_req      = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_row_clicks();
    test_repeat_timing();
    test_extreme_delays();
    test_steady_stream();
    test_output_holdoff();
    test_random_delays();

    drain_results();
    if (mismatch_count == 0 && exp_codes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
